FILE: rtl/core/rfc_pkg.sv
// Shared types and constants for the reciprocal frequency counter.
package rfc_pkg;

   localparam int PULSE_W   = 17;
   localparam int LIMIT_W   = 16;
   localparam int TIMEOUT_W = 16;
   localparam int CLOCK_W   = 32;
   localparam int OUT_W     = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_LIMIT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_MS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_CLOCK_HZ = 2'd2;

   localparam logic [LIMIT_W-1:0]   PULSE_LIMIT_RST  = 16'd1000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MS_RST   = 16'd100;
   localparam logic [CLOCK_W-1:0]   REF_CLOCK_HZ_RST = 32'd24000000;

   // One request, start_req in bit 0.
   typedef struct packed {
      logic ms_tick;
      logic edge_req;
      logic ref_tick;
      logic start_req;
   } req_item_type;

   // Measurement events raised by an accepted request.
   typedef struct packed {
      logic done;
      logic timeout;
   } meas_ev_type;

endpackage

FILE: rtl/core/rfc_div.sv
// Restoring divider, one quotient bit per cycle.
module rfc_div #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   // A zero divisor lets every trial succeed, so the quotient is all ones.
   always_comb begin
      trial = {rem_ff, q_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = diff[DIVISOR_W-1:0];
         q_in   = {q_ff[DIVIDEND_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DIVISOR_W-1:0];
         q_in   = {q_ff[DIVIDEND_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: rtl/core/rfc_meas.sv
// Measurement front end: arming, period and pulse counters, timeout.
module rfc_meas import rfc_pkg::*; #(
   parameter int PERIOD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  req_item_type           item,
   input  logic [LIMIT_W-1:0]     pulse_limit,
   input  logic [TIMEOUT_W-1:0]   timeout_ms,
   output meas_ev_type            ev,
   output logic [PERIOD_BITS-1:0] period
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_RUN,
      MODE_DONE
   } mode_type;

   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};
   localparam logic [PULSE_W-1:0]     PULSE_MAX  = {PULSE_W{1'b1}};

   mode_type               mode_ff, mode_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PULSE_W-1:0]     pulse_ff, pulse_in;
   logic [TIMEOUT_W-1:0]   left_ff, left_in;
   logic                   run;
   logic                   done_ev;
   logic                   tmo_ev;

   // Order within a request: start, reference tick, edge, millisecond tick.
   always_comb begin
      run = item.start_req || (mode_ff == MODE_RUN);

      period_in = item.start_req ? '0 : period_ff;
      if (run && item.ref_tick && (period_in != PERIOD_MAX)) begin
         period_in = period_in + 1'b1;
      end

      pulse_in = item.start_req ? '0 : pulse_ff;
      done_ev  = 1'b0;
      if (run && item.edge_req) begin
         if (pulse_in != PULSE_MAX) begin
            pulse_in = pulse_in + 1'b1;
         end
         done_ev = pulse_in > {1'b0, pulse_limit};
      end

      // completion wins over a timeout in the same request
      left_in = item.start_req ? timeout_ms : left_ff;
      tmo_ev  = 1'b0;
      if (run && !done_ev && item.ms_tick) begin
         if (left_in != '0) begin
            left_in = left_in - 1'b1;
         end
         tmo_ev = (left_in == '0);
      end

      mode_in = mode_ff;
      if (item.start_req) begin
         mode_in = MODE_RUN;
      end
      if (done_ev || tmo_ev) begin
         mode_in = MODE_DONE;
      end

      ev.done    = item_valid && done_ev;
      ev.timeout = item_valid && tmo_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         period_ff <= '0;
         pulse_ff  <= '0;
         left_ff   <= '0;
      end else if (item_valid) begin
         mode_ff   <= mode_in;
         period_ff <= period_in;
         pulse_ff  <= pulse_in;
         left_ff   <= left_in;
      end
   end

   assign period = period_ff;

endmodule

FILE: rtl/core/reciprocal_frequency_counter.sv
// Reciprocal frequency counter top level: registers, sequencer, result register.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    req_tdata: start_req, ref_tick, edge_req, ms_tick
//   rsp      out  rsp_tvalid/tready    rsp_tdata: period_ticks, frequency_hz; rsp_tuser: timed_out
//   csr      in   csr_we               csr_addr, csr_wdata
//
// Counting: one request per cycle while no result is pending.
// Completion: a load state, then two passes (ST_DIV1, ST_DIV2) on the shared serial divider
// (DIV_W = max(PERIOD_BITS, 32)), then the result waits in rsp until taken.
// Timeout: the result is registered the cycle after the request.
// req_tready stays low from a completing or timing-out request until its result is taken.
// Synchronous reset; no clearing pass.
module reciprocal_frequency_counter import rfc_pkg::*; #(
   parameter int PERIOD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // start_req, ref_tick, edge_req, ms_tick, 4'b0
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*OUT_W-1:0]    rsp_tdata,  // period_ticks[31:0], frequency_hz[63:32]
   output logic                  rsp_tuser,  // timed_out
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CLOCK_W-1:0]    csr_wdata
);

   localparam int DIV_W = (PERIOD_BITS > CLOCK_W) ? PERIOD_BITS : CLOCK_W;

   typedef enum logic [2:0] {
      ST_COUNT,
      ST_LOAD,
      ST_DIV1,
      ST_DIV2,
      ST_OUT
   } state_type;

   state_type              st_ff;
   logic [LIMIT_W-1:0]     pulse_limit_ff;
   logic [TIMEOUT_W-1:0]   timeout_ms_ff;
   logic [CLOCK_W-1:0]     ref_clock_ff;
   logic [2*OUT_W-1:0]     rsp_data_ff;
   logic                   rsp_user_ff;
   logic                   rsp_valid_ff;

   logic                   item_acc;
   req_item_type           item;
   meas_ev_type            ev;
   logic [PERIOD_BITS-1:0] period;
   logic [DIV_W-1:0]       period_x;
   logic [OUT_W-1:0]       period_sat;
   logic [LIMIT_W-1:0]     lim;
   logic                   div_go;
   logic [DIV_W-1:0]       div_dividend;
   logic [PERIOD_BITS-1:0] div_divisor;
   logic                   div_done;
   logic [DIV_W-1:0]       div_q;

   assign req_tready = (st_ff == ST_COUNT);
   assign item_acc   = req_tvalid && req_tready;
   assign item       = req_item_type'(req_tdata[3:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_limit_ff <= PULSE_LIMIT_RST;
         timeout_ms_ff  <= TIMEOUT_MS_RST;
         ref_clock_ff   <= REF_CLOCK_HZ_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PULSE_LIMIT:  pulse_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_TIMEOUT_MS:   timeout_ms_ff  <= csr_wdata[TIMEOUT_W-1:0];
            CSR_REF_CLOCK_HZ: ref_clock_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   rfc_meas #(
      .PERIOD_BITS(PERIOD_BITS)
   ) u_meas (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_acc),
      .item        (item),
      .pulse_limit (pulse_limit_ff),
      .timeout_ms  (timeout_ms_ff),
      .ev          (ev),
      .period      (period)
   );

   rfc_div #(
      .DIVIDEND_W(DIV_W),
      .DIVISOR_W (PERIOD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // First pass: period / limit. Second pass: clock / that quotient.
   always_comb begin
      period_x   = DIV_W'(period);
      period_sat = ((period_x >> OUT_W) != '0) ? '1 : period_x[OUT_W-1:0];
      lim        = (pulse_limit_ff == '0) ? LIMIT_W'(1) : pulse_limit_ff;
      div_go       = 1'b0;
      div_dividend = period_x;
      div_divisor  = PERIOD_BITS'(lim);
      case (st_ff)
         ST_LOAD: begin
            div_go = 1'b1;
         end
         ST_DIV1: begin
            div_go       = div_done;
            div_dividend = DIV_W'(ref_clock_ff);
            div_divisor  = div_q[PERIOD_BITS-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_COUNT;
         rsp_valid_ff <= 1'b0;
         rsp_user_ff  <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         case (st_ff)
            ST_COUNT: begin
               if (ev.done) begin
                  st_ff <= ST_LOAD;
               end else if (ev.timeout) begin
                  rsp_data_ff  <= '0;
                  rsp_user_ff  <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= ST_OUT;
               end
            end
            ST_LOAD: begin
               st_ff <= ST_DIV1;
            end
            ST_DIV1: begin
               if (div_done) begin
                  st_ff <= ST_DIV2;
               end
            end
            ST_DIV2: begin
               if (div_done) begin
                  rsp_data_ff  <= {div_q[OUT_W-1:0], period_sat};
                  rsp_user_ff  <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  st_ff        <= ST_COUNT;
               end
            end
            default: begin
               st_ff <= ST_COUNT;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (st_ff == ST_OUT))
      else $error("result valid outside output state");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("request accepted while result pending");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == '0))
      else $error("timeout result carries nonzero data");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (st_ff == ST_DIV1 || st_ff == ST_DIV2))
      else $error("divider finished outside a divide state");

   a_load_follows_done: assert property (@(posedge clock) disable iff (reset)
      ev.done |=> (st_ff == ST_LOAD))
      else $error("completion did not start the divide sequence");

endmodule
